// ===== design/tac_pkg.sv =====
package tac_pkg;

    localparam int DEPTH_DEF = 10;

    localparam int DEG_W  = 9;
    localparam int ADC_W  = 10;
    localparam int SUM_W  = 13;
    localparam int STEP_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [1:0] MODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_ON      = 2'd1;
    localparam logic [1:0] MODE_SETTING = 2'd2;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_INIT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MARGIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SETPOINT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SETPOINT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SETPOINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_STEP = 3'd4;

    localparam logic [DEG_W-1:0]  MARGIN_RST        = 9'd5;
    localparam logic [DEG_W-1:0]  MIN_SETPOINT_RST  = 9'd35;
    localparam logic [DEG_W-1:0]  MAX_SETPOINT_RST  = 9'd75;
    localparam logic [DEG_W-1:0]  INIT_SETPOINT_RST = 9'd60;
    localparam logic [STEP_W-1:0] SETPOINT_STEP_RST = 6'd5;

    localparam logic [DEG_W-1:0] DEG_MAX = '1;

    typedef struct packed {
        logic             fill;
        logic             push;
        logic [DEG_W-1:0] degrees;
    } ring_ctrl_t;

endpackage

// ===== design/tac_avg_ring.sv =====
module tac_avg_ring
    import tac_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ring_ctrl_t       ctrl,
    output logic [DEG_W-1:0] average_next
);

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int DIV_SHIFT = SUM_W + 5;
    localparam int RECIP_W   = DIV_SHIFT;
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + DEPTH - 1) / DEPTH;
    localparam int PROD_W    = SUM_W + RECIP_W;

    logic [DEG_W-1:0]  ring_reg [DEPTH];
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [PROD_W-1:0] prod;

    // The mean is taken by a multiplication with the rounded-up reciprocal of
    // DEPTH, which is exact for every value of the running sum.
    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        if (ctrl.fill)
        begin
            idx_next = '0;
            sum_next = SUM_W'(ctrl.degrees * DEPTH);
        end
        else if (ctrl.push)
        begin
            sum_next = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(ctrl.degrees);
            if (idx_reg == IDX_W'(DEPTH - 1))
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        prod = PROD_W'(sum_next) * PROD_W'(RECIP_W'(DIV_RECIP));
        average_next = prod[DIV_SHIFT +: DEG_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (ctrl.fill || (ctrl.push && idx_reg == IDX_W'(i)))
                begin
                    ring_reg[i] <= ctrl.degrees;
                end
            end
        end
    end

endmodule

// ===== design/thermostat_avg_controller.sv =====
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_stall    kind, mode, sample_valid, adc_code, key_up,
//                                             key_down, blink_phase
// out       out        out_valid / out_stall  heater_on ... average
//
// One request is taken per cycle while the result is not stalled; its result passes
// through an input register and a result register, with one pass of logic between them.
// The running sum update, the constant-reciprocal multiply and the deadband compare
// form that single path.
// Reset clears the sample ring, the sum and the last sample, returns the configuration
// to its defaults and the setpoint to 60.
// A stalled result holds the result register, and the input register then holds too.
module thermostat_avg_controller
    import tac_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [1:0]            mode,
    input  logic                  sample_valid,
    input  logic [ADC_W-1:0]      adc_code,
    input  logic                  key_up,
    input  logic                  key_down,
    input  logic                  blink_phase,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  heater_on,
    output logic                  cooler_on,
    output logic                  led_on,
    output logic                  display_on,
    output logic [DEG_W-1:0]      display_value,
    output logic                  enter_setting,
    output logic                  restart_setting_timer,
    output logic                  sleep_request,
    output logic [DEG_W-1:0]      average
);

    logic [DEG_W-1:0]  margin_reg;
    logic [DEG_W-1:0]  min_sp_reg;
    logic [DEG_W-1:0]  max_sp_reg;
    logic [STEP_W-1:0] step_reg;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_kind_reg;
    logic [1:0]        s1_mode_reg;
    logic              s1_sample_reg;
    logic [DEG_W-1:0]  s1_deg_reg;
    logic              s1_up_reg;
    logic              s1_down_reg;
    logic              s1_blink_reg;

    logic              accept;
    logic              advance;

    logic [DEG_W-1:0]  last_reg;
    logic [DEG_W-1:0]  last_next;
    logic [DEG_W-1:0]  setpoint_reg;
    logic [DEG_W-1:0]  setpoint_next;

    ring_ctrl_t        ring_ctrl;
    logic [DEG_W-1:0]  avg_next;

    logic              out_valid_reg;
    logic              heat_reg;
    logic              heat_next;
    logic              cool_reg;
    logic              cool_next;
    logic              led_reg;
    logic              led_next;
    logic              disp_reg;
    logic              disp_next;
    logic [DEG_W-1:0]  dval_reg;
    logic [DEG_W-1:0]  dval_next;
    logic              enter_reg;
    logic              enter_next;
    logic              restart_reg;
    logic              restart_next;
    logic              sleep_reg;
    logic              sleep_next;
    logic [DEG_W-1:0]  avg_reg;

    logic              below_hi;
    logic              above_lo;
    logic              stepped;
    logic [DEG_W:0]    sp_up;

    assign cfg_ready = 1'b1;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign s1_valid_next = accept || (s1_valid_reg && !advance);

    assign ring_ctrl.fill    = advance && s1_kind_reg == KIND_INIT;
    assign ring_ctrl.push    = advance && s1_kind_reg == KIND_TICK && s1_mode_reg == MODE_ON
                               && s1_sample_reg;
    assign ring_ctrl.degrees = s1_deg_reg;

    tac_avg_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ring_ctrl),
        .average_next (avg_next)
    );

    always_comb
    begin
        below_hi = {1'b0, setpoint_reg} < ({1'b0, avg_next} + {1'b0, margin_reg});
        above_lo = ({1'b0, setpoint_reg} + {1'b0, margin_reg}) > {1'b0, avg_next};
        sp_up    = {1'b0, setpoint_reg} + (DEG_W+1)'(step_reg);

        last_next     = last_reg;
        setpoint_next = setpoint_reg;
        stepped       = 1'b0;
        heat_next     = 1'b0;
        cool_next     = 1'b0;
        led_next      = 1'b0;
        disp_next     = 1'b0;
        dval_next     = '0;
        enter_next    = 1'b0;
        restart_next  = 1'b0;
        sleep_next    = 1'b0;

        if (s1_kind_reg == KIND_TICK)
        begin
            case (s1_mode_reg)
                MODE_ON:
                begin
                    if (s1_sample_reg)
                    begin
                        last_next = s1_deg_reg;
                    end
                    if (below_hi && !above_lo)
                    begin
                        cool_next = 1'b1;
                    end
                    else if (above_lo && !below_hi)
                    begin
                        heat_next = 1'b1;
                        led_next  = s1_blink_reg;
                    end
                    if (s1_up_reg || s1_down_reg)
                    begin
                        enter_next   = 1'b1;
                        restart_next = 1'b1;
                    end
                    else
                    begin
                        disp_next = 1'b1;
                        dval_next = last_next;
                    end
                end
                MODE_SETTING:
                begin
                    if (s1_up_reg && setpoint_reg < max_sp_reg)
                    begin
                        setpoint_next = sp_up[DEG_W] ? DEG_MAX : sp_up[DEG_W-1:0];
                        stepped       = 1'b1;
                    end
                    else if (s1_down_reg && setpoint_reg > min_sp_reg)
                    begin
                        setpoint_next = (setpoint_reg >= DEG_W'(step_reg))
                                        ? setpoint_reg - DEG_W'(step_reg) : '0;
                        stepped       = 1'b1;
                    end
                    restart_next = stepped;
                    if (stepped || s1_blink_reg)
                    begin
                        disp_next = 1'b1;
                        dval_next = setpoint_next;
                    end
                end
                default:
                begin
                    sleep_next = 1'b1;
                end
            endcase
        end
    end

    // The initial setpoint is only loaded at reset, and reset also restores its
    // default, so a write to that register has no visible effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RST;
            min_sp_reg <= MIN_SETPOINT_RST;
            max_sp_reg <= MAX_SETPOINT_RST;
            step_reg   <= SETPOINT_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MARGIN:        margin_reg <= cfg_data;
                REG_MIN_SETPOINT:  min_sp_reg <= cfg_data;
                REG_MAX_SETPOINT:  max_sp_reg <= cfg_data;
                REG_INIT_SETPOINT: ;
                REG_SETPOINT_STEP: step_reg   <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            setpoint_reg  <= INIT_SETPOINT_RST;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                last_reg      <= last_next;
                setpoint_reg  <= setpoint_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= kind;
            s1_mode_reg   <= mode;
            s1_sample_reg <= sample_valid;
            s1_deg_reg    <= adc_code[ADC_W-1:1];
            s1_up_reg     <= key_up;
            s1_down_reg   <= key_down;
            s1_blink_reg  <= blink_phase;
        end
        if (advance)
        begin
            heat_reg    <= heat_next;
            cool_reg    <= cool_next;
            led_reg     <= led_next;
            disp_reg    <= disp_next;
            dval_reg    <= dval_next;
            enter_reg   <= enter_next;
            restart_reg <= restart_next;
            sleep_reg   <= sleep_next;
            avg_reg     <= avg_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign heater_on             = heat_reg;
    assign cooler_on             = cool_reg;
    assign led_on                = led_reg;
    assign display_on            = disp_reg;
    assign display_value         = dval_reg;
    assign enter_setting         = enter_reg;
    assign restart_setting_timer = restart_reg;
    assign sleep_request         = sleep_reg;
    assign average               = avg_reg;

endmodule
